### design/tkhh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkhh_pkg
// Shared types, constants and helpers for the top-k heavy-hitter table.
// ---------------------------------------------------------------------------
package tkhh_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int ACT_W       = 2;

    localparam logic [VAL_W-1:0] ALL32 = {VAL_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

    localparam logic [ACT_W-1:0] ACT_INC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] est;
        logic [VAL_W-1:0] hits;
    } entry_t;

    typedef struct packed {
        logic             load;
        logic             scan;
        logic [IDX_W-1:0] addr;
        logic             apply;
    } tkhh_cmd_t;

    typedef struct packed {
        logic out_free;
    } tkhh_status_t;

    function automatic logic [VAL_W-1:0] sat_total(input logic [VAL_W-1:0] est,
                                                   input logic [VAL_W-1:0] hits);
        logic [VAL_W:0] s;
        s = {1'b0, est} + {1'b0, hits};
        return s[VAL_W] ? ALL32 : s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

### design/tkhh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkhh_ctrl
// Sequencer: accept a transaction, sweep all slots, drain, then commit.
// ---------------------------------------------------------------------------
module tkhh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tkhh_pkg::tkhh_status_t status,
    output tkhh_pkg::tkhh_cmd_t        cmd
);
    import tkhh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_APPLY
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    addr_reg <= '0;
                    if (in_valid)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == IDX_W'(MAX_ENTRIES - 1))
                        state_reg <= ST_DRAIN1;
                end
                ST_DRAIN1: state_reg <= ST_DRAIN2;
                ST_DRAIN2: state_reg <= ST_APPLY;
                ST_APPLY:
                begin
                    // hold until the result register can take the new result
                    if (status.out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.addr  = addr_reg;
    assign cmd.apply = (state_reg == ST_APPLY) && status.out_free;

endmodule
`default_nettype wire

### design/tkhh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkhh_datapath
// Slot memory, scan pipeline, running minimums and the result register.
// ---------------------------------------------------------------------------
module tkhh_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tkhh_pkg::tkhh_cmd_t            cmd,
    output tkhh_pkg::tkhh_status_t              status,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tkhh_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic [tkhh_pkg::ACT_W-1:0]     action,
    input  wire logic [tkhh_pkg::KEY_W-1:0]     fingerprint,
    input  wire logic [tkhh_pkg::VAL_W-1:0]     base_estimate,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                found,
    output logic [tkhh_pkg::VAL_W-1:0]          total,
    output logic                                evicted_valid,
    output logic [tkhh_pkg::KEY_W-1:0]          evicted_key,
    output logic [tkhh_pkg::VAL_W-1:0]          evicted_estimate,
    output logic [tkhh_pkg::VAL_W-1:0]          evicted_hits,
    output logic [tkhh_pkg::VAL_W-1:0]          minimum_total
);
    import tkhh_pkg::*;

    entry_t mem [0:MAX_ENTRIES-1];

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]       occ_reg;
    logic [VAL_W-1:0]       least_reg;
    logic [CAP_W-1:0]       cap_reg;

    logic [ACT_W-1:0] act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] est_reg;

    // stage A: memory read
    logic             a_vld_reg;
    entry_t           a_data_reg;
    logic             a_valid_reg;
    logic [IDX_W-1:0] a_idx_reg;
    // stage B: total and key compare
    logic             b_vld_reg;
    entry_t           b_data_reg;
    logic             b_valid_reg;
    logic             b_match_reg;
    logic [VAL_W-1:0] b_total_reg;
    logic [IDX_W-1:0] b_idx_reg;

    // accumulators
    logic             m_found_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [VAL_W-1:0] m_est_reg;
    logic [VAL_W-1:0] m_hits_reg;
    logic             f_found_reg;
    logic [IDX_W-1:0] f_idx_reg;
    logic             e_found_reg;
    entry_t           e_data_reg;
    logic [IDX_W-1:0] e_idx_reg;
    logic             min1_any_reg;
    logic [VAL_W-1:0] min1_reg;
    logic [IDX_W-1:0] min1_idx_reg;
    logic             min2_any_reg;
    logic [VAL_W-1:0] min2_reg;

    logic                 out_valid_reg;
    logic                 found_reg;
    logic [VAL_W-1:0]     total_reg;
    logic                 ev_valid_reg;
    entry_t               ev_data_reg;
    logic [VAL_W-1:0]     min_out_reg;

    // commit decode
    logic             do_write;
    logic [IDX_W-1:0] s_idx;
    logic             s_was_valid;
    logic [VAL_W-1:0] new_est;
    logic [VAL_W-1:0] new_hits;
    logic [VAL_W-1:0] new_total;
    logic             found_next;
    logic [VAL_W-1:0] total_next;
    logic             ev_next;
    logic             grow;
    logic             full;
    logic [CNT_W-1:0] eff_cap;
    logic             excl_any;
    logic [VAL_W-1:0] excl_min;
    logic [VAL_W-1:0] min_next;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (cap_reg > CAP_W'(MAX_ENTRIES))
            eff_cap = CNT_W'(MAX_ENTRIES);
        else
            eff_cap = CNT_W'(cap_reg);
    end

    assign full = (occ_reg >= eff_cap);

    always_comb
    begin
        do_write    = 1'b0;
        s_idx       = m_idx_reg;
        s_was_valid = 1'b0;
        new_est     = est_reg;
        new_hits    = VAL_W'(1);
        found_next  = 1'b0;
        total_next  = '0;
        ev_next     = 1'b0;
        grow        = 1'b0;
        case (act_reg)
            ACT_INC:
            begin
                if (m_found_reg)
                begin
                    do_write    = 1'b1;
                    s_was_valid = 1'b1;
                    new_est     = m_est_reg;
                    new_hits    = (m_hits_reg == ALL32) ? m_hits_reg : m_hits_reg + 1'b1;
                    found_next  = 1'b1;
                    total_next  = sat_total(m_est_reg, new_hits);
                end
            end
            ACT_ADD:
            begin
                do_write = 1'b1;
                if (m_found_reg)
                    s_was_valid = 1'b1;
                else if (full)
                begin
                    s_idx       = e_found_reg ? e_idx_reg : '0;
                    s_was_valid = 1'b1;
                    ev_next     = 1'b1;
                end
                else
                begin
                    s_idx = f_idx_reg;
                    grow  = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                if (m_found_reg)
                begin
                    found_next = 1'b1;
                    total_next = sat_total(m_est_reg, m_hits_reg);
                end
            end
            default: ;
        endcase

        new_total = sat_total(new_est, new_hits);

        // minimum over the other slots, then fold in the rewritten one
        if (s_was_valid && (s_idx == min1_idx_reg))
        begin
            excl_any = min2_any_reg;
            excl_min = min2_reg;
        end
        else
        begin
            excl_any = min1_any_reg;
            excl_min = min1_reg;
        end

        if (do_write)
            min_next = (excl_any && (excl_min < new_total)) ? excl_min : new_total;
        else
            min_next = min1_any_reg ? min1_reg : '0;
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    // slot memory: one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.apply && do_write)
            mem[s_idx] <= '{key: key_reg, est: new_est, hits: new_hits};
        a_data_reg <= mem[cmd.addr];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= fingerprint;
            est_reg <= base_estimate;
        end
        a_valid_reg <= valid_reg[cmd.addr];
        a_idx_reg   <= cmd.addr;
        b_data_reg  <= a_data_reg;
        b_valid_reg <= a_valid_reg;
        b_match_reg <= a_valid_reg && (a_data_reg.key == key_reg);
        b_total_reg <= sat_total(a_data_reg.est, a_data_reg.hits);
        b_idx_reg   <= a_idx_reg;

        if (b_vld_reg)
        begin
            if (b_match_reg && !m_found_reg)
            begin
                m_idx_reg  <= b_idx_reg;
                m_est_reg  <= b_data_reg.est;
                m_hits_reg <= b_data_reg.hits;
            end
            if (!b_valid_reg && !f_found_reg)
                f_idx_reg <= b_idx_reg;
            if (b_valid_reg && !e_found_reg && (b_total_reg == least_reg))
            begin
                e_idx_reg  <= b_idx_reg;
                e_data_reg <= b_data_reg;
            end
            if (b_valid_reg)
            begin
                if (!min1_any_reg || (b_total_reg < min1_reg))
                begin
                    min1_reg     <= b_total_reg;
                    min1_idx_reg <= b_idx_reg;
                    min2_reg     <= min1_reg;
                end
                else if (!min2_any_reg || (b_total_reg < min2_reg))
                    min2_reg <= b_total_reg;
            end
        end

        if (cmd.apply)
        begin
            found_reg   <= found_next;
            total_reg   <= total_next;
            ev_valid_reg <= ev_next;
            ev_data_reg <= ev_next ? e_data_reg : '0;
            min_out_reg <= min_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            least_reg     <= '0;
            cap_reg       <= CAP_RESET;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            m_found_reg   <= 1'b0;
            f_found_reg   <= 1'b0;
            e_found_reg   <= 1'b0;
            min1_any_reg  <= 1'b0;
            min2_any_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            a_vld_reg <= cmd.scan;
            b_vld_reg <= a_vld_reg;

            if (cmd.load)
            begin
                m_found_reg  <= 1'b0;
                f_found_reg  <= 1'b0;
                e_found_reg  <= 1'b0;
                min1_any_reg <= 1'b0;
                min2_any_reg <= 1'b0;
            end
            else if (b_vld_reg)
            begin
                if (b_match_reg)
                    m_found_reg <= 1'b1;
                if (!b_valid_reg)
                    f_found_reg <= 1'b1;
                if (b_valid_reg && (b_total_reg == least_reg))
                    e_found_reg <= 1'b1;
                if (b_valid_reg)
                begin
                    if (!min1_any_reg || (b_total_reg < min1_reg))
                        min2_any_reg <= min1_any_reg;
                    else
                        min2_any_reg <= 1'b1;
                    min1_any_reg <= 1'b1;
                end
            end

            if (cmd.apply)
            begin
                out_valid_reg <= 1'b1;
                least_reg     <= min_next;
                if (do_write)
                    valid_reg[s_idx] <= 1'b1;
                if (grow)
                    occ_reg <= occ_reg + 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign total            = total_reg;
    assign evicted_valid    = ev_valid_reg;
    assign evicted_key      = ev_data_reg.key;
    assign evicted_estimate = ev_data_reg.est;
    assign evicted_hits     = ev_data_reg.hits;
    assign minimum_total    = min_out_reg;

endmodule
`default_nettype wire

### design/top_k_heavy_hitter_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_heavy_hitter_table_unit
// Flow table keeping the heaviest flows, evicting the lowest total when full.
// ---------------------------------------------------------------------------
// Channel   Handshake             Payload
// in        in_valid / in_stall   action, fingerprint, base_estimate
// out       out_valid / out_stall found, total, evicted_*, minimum_total
// cfg       cfg_wr_en             cfg_wr_data (capacity)
//
// One transaction is a serial sweep of the slot memory through its single read
// port, a drain through pipeline stages A and B, and one commit.
// The next transaction is accepted while a result waits in the output register;
// commit holds while that register is full and stalled.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module top_k_heavy_hitter_table_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [tkhh_pkg::CAP_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [tkhh_pkg::ACT_W-1:0] action,
    input  wire logic [tkhh_pkg::KEY_W-1:0] fingerprint,
    input  wire logic [tkhh_pkg::VAL_W-1:0] base_estimate,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            found,
    output logic [tkhh_pkg::VAL_W-1:0]      total,
    output logic                            evicted_valid,
    output logic [tkhh_pkg::KEY_W-1:0]      evicted_key,
    output logic [tkhh_pkg::VAL_W-1:0]      evicted_estimate,
    output logic [tkhh_pkg::VAL_W-1:0]      evicted_hits,
    output logic [tkhh_pkg::VAL_W-1:0]      minimum_total
);
    import tkhh_pkg::*;

    tkhh_cmd_t    cmd;
    tkhh_status_t status;

    tkhh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tkhh_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .action           (action),
        .fingerprint      (fingerprint),
        .base_estimate    (base_estimate),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .found            (found),
        .total            (total),
        .evicted_valid    (evicted_valid),
        .evicted_key      (evicted_key),
        .evicted_estimate (evicted_estimate),
        .evicted_hits     (evicted_hits),
        .minimum_total    (minimum_total)
    );

endmodule
`default_nettype wire

### verif/tb_top_k_heavy_hitter_table_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heavy-hitter flow table testbench
// Drives increment, add, query and unused-action transactions through several capacity
// settings under random idling and back-pressure, and checks each result
// against an in-bench model of the table.
// ---------------------------------------------------------------------------
module tb_top_k_heavy_hitter_table_unit;
    import tkhh_pkg::*;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] fp;
        logic [VAL_W-1:0] est;
    } flow_op_t;

    typedef struct packed {
        logic             fnd;
        logic [VAL_W-1:0] tot;
        logic             ev_v;
        logic [KEY_W-1:0] ev_key;
        logic [VAL_W-1:0] ev_est;
        logic [VAL_W-1:0] ev_hits;
        logic [VAL_W-1:0] min_tot;
    } flow_res_t;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACT_W-1:0] action = '0;
    logic [KEY_W-1:0] fingerprint = '0;
    logic [VAL_W-1:0] base_estimate = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found, evicted_valid;
    logic [VAL_W-1:0] total, evicted_estimate, evicted_hits, minimum_total;
    logic [KEY_W-1:0] evicted_key;

    top_k_heavy_hitter_table_unit uut (.*);

    always #6 clk = ~clk;

    // table model
    logic             tbl_valid [MAX_ENTRIES];
    logic [KEY_W-1:0] tbl_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] tbl_est   [MAX_ENTRIES];
    logic [VAL_W-1:0] tbl_hits  [MAX_ENTRIES];
    int               tbl_occ = 0;
    logic [VAL_W-1:0] tbl_min = '0;
    int               tbl_cap = MAX_ENTRIES;

    flow_op_t  pending_ops[$];
    flow_res_t expected_results[$];
    int errors = 0, accepted = 0, returned = 0, evictions = 0, idle_cycles = 0;
    int send_idle_pct = 25, recv_idle_pct = 56, hold_left = 0;

    function automatic logic [VAL_W-1:0] flow_total(input int i);
        logic [VAL_W:0] s;
        s = {1'b0, tbl_est[i]} + {1'b0, tbl_hits[i]};
        return s[VAL_W] ? ALL32 : s[VAL_W-1:0];
    endfunction

    function automatic flow_res_t apply_flow_op(input flow_op_t op);
        flow_res_t r;
        int s, cap;
        logic any;
        r = '0;
        s = -1;
        any = 1'b0;
        cap = (tbl_cap == 0) ? 1 : (tbl_cap > MAX_ENTRIES ? MAX_ENTRIES : tbl_cap);
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_key[i] == op.fp) s = i;
        if (op.act == ACT_INC || op.act == ACT_QUERY) begin
            if (s >= 0) begin
                if (op.act == ACT_INC && tbl_hits[s] != ALL32) tbl_hits[s]++;
                r.fnd = 1'b1;
                r.tot = flow_total(s);
            end
        end else if (op.act == ACT_ADD) begin
            if (s < 0) begin
                if (tbl_occ >= cap) begin
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                        if (tbl_valid[i] && flow_total(i) == tbl_min) s = i;
                    if (s < 0) s = 0;
                    r.ev_v = 1'b1;
                    r.ev_key = tbl_key[s];
                    r.ev_est = tbl_est[s];
                    r.ev_hits = tbl_hits[s];
                end else begin
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                        if (!tbl_valid[i]) s = i;
                    tbl_occ++;
                end
            end
            tbl_valid[s] = 1'b1;
            tbl_key[s] = op.fp;
            tbl_est[s] = op.est;
            tbl_hits[s] = 1;
        end
        tbl_min = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (tbl_valid[i]) begin
                if (!any || flow_total(i) < tbl_min) tbl_min = flow_total(i);
                any = 1'b1;
            end
        r.min_tot = tbl_min;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            expected_results.push_back(apply_flow_op({action, fingerprint, base_estimate}));
            accepted++;
        end
        if (!in_valid || !in_stall) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                flow_op_t op;
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                action <= op.act;
                fingerprint <= op.fp;
                base_estimate <= op.est;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                returned++;
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    errors++;
                end else begin
                    flow_res_t e;
                    e = expected_results.pop_front();
                    if (evicted_valid) evictions++;
                    if (found !== e.fnd) begin
                        $error("found exp %0h got %0h", e.fnd, found); errors++;
                    end
                    if (total !== e.tot) begin
                        $error("total exp %0h got %0h", e.tot, total); errors++;
                    end
                    if (evicted_valid !== e.ev_v) begin
                        $error("evicted_valid exp %0h got %0h", e.ev_v, evicted_valid);
                        errors++;
                    end
                    if (evicted_key !== e.ev_key) begin
                        $error("evicted_key exp %0h got %0h", e.ev_key, evicted_key);
                        errors++;
                    end
                    if (evicted_estimate !== e.ev_est) begin
                        $error("evicted_estimate exp %0h got %0h", e.ev_est,
                               evicted_estimate);
                        errors++;
                    end
                    if (evicted_hits !== e.ev_hits) begin
                        $error("evicted_hits exp %0h got %0h", e.ev_hits, evicted_hits);
                        errors++;
                    end
                    if (minimum_total !== e.min_tot) begin
                        $error("minimum_total exp %0h got %0h", e.min_tot, minimum_total);
                        errors++;
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    logic [KEY_W-1:0] key_pool [16];

    function automatic logic [VAL_W-1:0] rand_est();
        case ($urandom_range(4))
            0: return '0;
            1: return ALL32 - $urandom_range(3);
            2: return $urandom_range(20);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(input logic [ACT_W-1:0] a, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] e);
        flow_op_t op;
        op.act = a;
        op.fp = k;
        op.est = e;
        pending_ops.push_back(op);
    endtask

    task automatic drain();
        wait (pending_ops.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tbl_cap = c;
    endtask

    task automatic random_phase(input int n);
        logic [ACT_W-1:0] a;
        logic [KEY_W-1:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            a = (r < 40) ? ACT_INC : (r < 70) ? ACT_ADD : (r < 95) ? ACT_QUERY : ACT_NONE;
            k = ($urandom_range(9) == 0) ? {$urandom(), $urandom()}
                                         : key_pool[$urandom_range(15)];
            queue_op(a, k, rand_est());
        end
    endtask

    int caps [7] = '{1, 3, 127, 0, 8, 64, 2};

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default capacity, extremes, saturation, unused action
        queue_op(ACT_QUERY, '0, '0);
        queue_op(ACT_INC, '1, '0);
        queue_op(ACT_ADD, '0, '0);
        queue_op(ACT_ADD, '1, ALL32);
        queue_op(ACT_INC, '1, '0);
        queue_op(ACT_QUERY, '1, '0);
        queue_op(ACT_ADD, 64'h5555_aaaa_5555_aaaa, ALL32 - 1);
        queue_op(ACT_INC, 64'h5555_aaaa_5555_aaaa, '0);
        queue_op(ACT_INC, '0, '0);
        queue_op(ACT_ADD, '0, 32'h5555_aaaa);
        queue_op(ACT_NONE, '0, '1);
        queue_op(ACT_QUERY, 64'haaaa_5555_aaaa_5555, '0);
        drain();
        set_capacity(2);
        queue_op(ACT_ADD, 64'h1234, 7);
        queue_op(ACT_ADD, 64'h5678, 3);
        queue_op(ACT_ADD, 64'h9abc, 3);
        queue_op(ACT_QUERY, 64'h9abc, '0);
        drain();

        send_idle_pct = 25;
        recv_idle_pct = 56;
        for (int p = 0; p < 7; p++) begin
            if (p == 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 25;
            end
            if (p == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_capacity(caps[p]);
            if (p == 2) hold_left = 400;
            random_phase(195);
            drain();
        end

        $display("Covered %0d transactions over capacities 1..127 and 0, %0d evictions.",
                 accepted, evictions);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
